// ===== rtl/dual_crc16_frame_checker_defines.svh =====
// assertion macros used by the checker file
`ifndef DUAL_CRC16_FRAME_CHECKER_DEFINES_SVH
`define DUAL_CRC16_FRAME_CHECKER_DEFINES_SVH

// concurrent assertion on the block clock, off while reset is held
`define DCRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent assertion on the block clock that also holds during reset
`define DCRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/dcrc_pkg.sv =====
// types, constants and the byte-wide crc update for the dual crc-16 checker
package dcrc_pkg;

    localparam int unsigned CrcW  = 16;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;

    typedef logic [CrcW-1:0]  t_crc;
    typedef logic [ByteW-1:0] t_byte;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_crc CRC_INIT          = 16'hFFFF;
    localparam t_crc CRC_TOP           = 16'h8000;
    localparam t_crc HEADER_POLY_RESET = 16'hC86C;
    localparam t_crc DATA_POLY_RESET   = 16'hBAAD;

    localparam t_cfg_idx CFG_HEADER_POLY = 2'd0;
    localparam t_cfg_idx CFG_DATA_POLY   = 2'd1;

    localparam logic CH_HEADER  = 1'b0;
    localparam logic CH_PAYLOAD = 1'b1;

    // msb-first fold of one byte, eight shift/xor steps unrolled
    function automatic t_crc crc_fold_byte(input t_crc crc, input t_byte data,
                                           input t_crc poly);
        t_crc c;
        c = crc ^ {data, {(CrcW-ByteW){1'b0}}};
        for (int k = 0; k < ByteW; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CrcW-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CrcW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/dual_crc16_frame_checker.sv =====
// Dual CRC-16 frame checker: two MSB-first CRC-16 channels (init 0xFFFF, no
// reflection, no final xor), header and payload, each with a programmable
// polynomial (register 0 header_poly, reset 0xC86C; register 1 data_poly,
// reset 0xBAAD). Each accepted item folds one byte into the channel that
// i_mode selects; an item marked last yields one result (channel, crc,
// match against i_expected_crc) and returns that channel to 0xFFFF. Every
// item passes an input register, then the unrolled eight-step byte update
// into the result register: one item per cycle while the input side does
// not stall, and a result is held on the output ports until it is taken.
// The input side stalls only while
// a result waits in the output register and the item in the input register
// would produce another. Config writes are always ready and take effect on
// bytes folded after the write.
module dual_crc16_frame_checker
    import dcrc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input items
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_mode,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [15:0]    i_expected_crc,
    // result items
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_channel,
    output logic [15:0]    o_crc_value,
    output logic           o_crc_match,
    // configuration writes
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);

    // configuration
    t_crc r_header_poly, r_data_poly;

    // running crc per channel
    t_crc r_header_crc, n_header_crc;
    t_crc r_payload_crc, n_payload_crc;

    // input register
    logic  r_s1_valid;
    logic  r_s1_mode;
    t_byte r_s1_byte;
    logic  r_s1_last;
    t_crc  r_s1_expect;

    // result register
    logic  r_out_valid;
    logic  r_out_channel;
    t_crc  r_out_crc;
    logic  r_out_match;

    logic  out_free;
    logic  s1_move;
    logic  in_accept;
    t_crc  sel_crc;
    t_crc  sel_poly;
    t_crc  folded;

    assign out_free  = !r_out_valid || !i_stall;
    assign s1_move   = r_s1_valid && (!r_s1_last || out_free);
    assign o_stall   = r_s1_valid && !s1_move;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        sel_crc  = (r_s1_mode == CH_PAYLOAD) ? r_payload_crc : r_header_crc;
        sel_poly = (r_s1_mode == CH_PAYLOAD) ? r_data_poly : r_header_poly;
        folded   = crc_fold_byte(sel_crc, r_s1_byte, sel_poly);
    end

    always_comb begin
        n_header_crc  = r_header_crc;
        n_payload_crc = r_payload_crc;
        if (s1_move) begin
            // a finished message restarts its channel
            if (r_s1_mode == CH_PAYLOAD) begin
                n_payload_crc = r_s1_last ? CRC_INIT : folded;
            end else begin
                n_header_crc = r_s1_last ? CRC_INIT : folded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_poly <= HEADER_POLY_RESET;
            r_data_poly   <= DATA_POLY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEADER_POLY: r_header_poly <= i_cfg_data;
                CFG_DATA_POLY:   r_data_poly   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_crc  <= CRC_INIT;
            r_payload_crc <= CRC_INIT;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_header_crc  <= n_header_crc;
            r_payload_crc <= n_payload_crc;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= s1_move && r_s1_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode   <= i_mode;
            r_s1_byte   <= i_data_byte;
            r_s1_last   <= i_last_byte;
            r_s1_expect <= i_expected_crc;
        end
        if (out_free && s1_move && r_s1_last) begin
            r_out_channel <= r_s1_mode;
            r_out_crc     <= folded;
            r_out_match   <= (folded == r_s1_expect);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_channel   = r_out_channel;
    assign o_crc_value = r_out_crc;
    assign o_crc_match = r_out_match;

endmodule

// ===== rtl/dcrc_checker.sv =====
// port-level assertions for the dual crc-16 checker, bound to the top level
`include "dual_crc16_frame_checker_defines.svh"

module dcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_channel,
    input logic [15:0] o_crc_value,
    input logic        o_crc_match
);

    // a waiting result holds its fields
    `DCRC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_crc_value) && $stable(o_channel) && $stable(o_crc_match), "result changed while stalled")

    // input only stalls behind a stalled result
    `DCRC_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without a blocked result")

    // a last byte reaches the output once the output side lets it through
    `DCRC_ASSERT(a_last_delivers, (i_valid && !o_stall && i_last_byte) ##1 !i_stall |=> o_valid, "last byte produced no result")

    // nothing comes out right after reset
    `DCRC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid && !o_stall, "result or stall present after reset")

endmodule

bind dual_crc16_frame_checker dcrc_checker u_dcrc_checker (.*);
